FILE: rtl/core/wdb_pkg.sv
// Shared definitions for the window density blob detector.
// Register indexes, reset values, field widths and the structs passed
// between the core modules. No dependencies.
package wdb_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_KERNEL    = 7;

    localparam int SAMPLE_W   = 16;
    localparam int DIM_W      = 11;
    localparam int COORD_W    = 10;
    localparam int CTH_W      = 7;
    localparam int SLOT_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_SLOT       = 3'd4;

    localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH     = 11'd640;
    localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT    = 11'd480;
    localparam logic [SAMPLE_W-1:0] RST_FG_THRESHOLD    = 16'd3277;
    localparam logic [CTH_W-1:0]    RST_COUNT_THRESHOLD = 7'd25;
    localparam logic [SLOT_W-1:0]   RST_LAST_SLOT       = 10'd998;

    // Output queue depth covers the two pipeline stages plus skid room.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_LVL_W = 3;

    typedef struct packed {
        logic valid;
        logic active;
        logic frame_start;
        logic judge;
    } t_ctl;

    typedef struct packed {
        logic [COORD_W-1:0]  centre_x;
        logic [COORD_W-1:0]  centre_y;
        logic [SAMPLE_W-1:0] centre_value;
        logic [SLOT_W-1:0]   slot;
        logic                wrapped;
    } t_det;

endpackage

FILE: rtl/core/wdb_fifo.sv
// Small output queue that decouples the detection pipeline from the
// result channel. Depends on wdb_pkg for the detection record type.
module wdb_fifo
    import wdb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_det                 i_det,
    input  logic                 i_stall,
    output logic                 o_valid,
    output t_det                 o_det,
    output logic [OUT_LVL_W-1:0] o_level
);

    t_det                 r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wp;
    logic [OUT_PTR_W-1:0] r_rp;
    logic [OUT_LVL_W-1:0] r_lvl;
    logic                 pop;

    assign o_valid = (r_lvl != '0);
    assign pop     = o_valid && !i_stall;
    assign o_det   = r_mem[r_rp];
    assign o_level = r_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_lvl <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_lvl <= r_lvl + OUT_LVL_W'(i_push) - OUT_LVL_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_det;
        end
    end

endmodule

FILE: rtl/core/wdb_store.sv
// Line stores of the detector: a column-organized foreground bit memory
// with read-modify-write and forwarding, and a sample memory holding the
// rows a centre may lag behind. Depends on wdb_pkg.
module wdb_store
    import wdb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int KERNEL    = DEF_KERNEL
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctl                        i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  logic [DIM_W-1:0]            i_row,
    input  logic [$clog2(2*(KERNEL/2)+2)-1:0] i_lane_f,
    input  logic [$clog2(KERNEL/2+1)-1:0]     i_lane_s,
    input  logic                        i_fg,
    input  logic [SAMPLE_W-1:0]         i_sample,
    output logic                        o_clearing,
    output logic                        o_p1_valid,
    output t_ctl                        o_ctl,
    output logic [$clog2(2*(KERNEL/2)+3)-1:0] o_col_cnt,
    output logic                        o_cbit,
    output logic [SAMPLE_W-1:0]         o_csample,
    output logic [COORD_W-1:0]          o_ci,
    output logic [COORD_W-1:0]          o_cj
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int HALF_HI = KERNEL / 2;
    localparam int WIN     = 2 * HALF_HI + 2;
    localparam int SR      = HALF_HI + 1;
    localparam int LFW     = $clog2(WIN);
    localparam int LSW     = $clog2(SR);
    localparam int CCW     = $clog2(WIN + 1);
    localparam int SA      = LSW + CW;
    localparam int CJW     = (CW > COORD_W) ? CW : COORD_W;

    function automatic logic [CCW-1:0] f_ones(input logic [WIN-1:0] v);
        logic [CCW-1:0] s;
        s = '0;
        for (int k = 0; k < WIN; k++) begin
            s = s + CCW'(v[k]);
        end
        return s;
    endfunction

    logic [WIN-1:0]      r_fmem [2**CW];
    logic [SAMPLE_W-1:0] r_smem [2**SA];

    logic          r_clr_busy;
    logic [SA-1:0] r_clr_addr;

    logic [WIN-1:0]      r_frd;
    logic [SAMPLE_W-1:0] r_srd;
    logic                r_fwd;
    logic [WIN-1:0]      r_fwd_word;

    t_ctl             r_p1_ctl;
    logic [CW-1:0]    r_p1_col;
    logic [DIM_W-1:0] r_p1_row;
    logic [LFW-1:0]   r_p1_lane_f;
    logic             r_p1_fg;

    t_ctl                r_p2_ctl;
    logic [CCW-1:0]      r_p2_cnt;
    logic                r_p2_cbit;
    logic [SAMPLE_W-1:0] r_p2_csamp;
    logic [COORD_W-1:0]  r_p2_ci;
    logic [COORD_W-1:0]  r_p2_cj;

    logic [LSW-1:0]   lane_sr;
    logic [LFW-1:0]   lane_fc;
    logic [WIN-1:0]   n_word;
    logic             p1_write;
    logic [DIM_W-1:0] ci_full;
    logic [CJW-1:0]   cj_full;

    // The centre row of a later window sits in the lane after the one written now.
    assign lane_sr = (i_lane_s == LSW'(SR - 1)) ? '0 : i_lane_s + 1'b1;
    assign lane_fc = (r_p1_lane_f >= LFW'(HALF_HI)) ? r_p1_lane_f - LFW'(HALF_HI)
                                                    : r_p1_lane_f + LFW'(WIN - HALF_HI);
    assign p1_write = r_p1_ctl.valid && r_p1_ctl.active;
    assign ci_full  = r_p1_row - DIM_W'(HALF_HI);
    assign cj_full  = CJW'(r_p1_col) - CJW'(HALF_HI);

    always_comb begin
        n_word = r_fwd ? r_fwd_word : r_frd;
        n_word[r_p1_lane_f] = r_p1_fg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_fmem[r_clr_addr[CW-1:0]] <= '0;
        end else if (p1_write) begin
            r_fmem[r_p1_col] <= n_word;
        end
        if (i_ctl.valid) begin
            r_frd <= r_fmem[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_smem[r_clr_addr] <= '0;
        end else if (i_ctl.valid && i_ctl.active) begin
            r_smem[{i_lane_s, i_col}] <= i_sample;
        end
        if (i_ctl.valid) begin
            r_srd <= r_smem[{lane_sr, i_col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_ctl <= '0;
            r_p2_ctl <= '0;
        end else begin
            r_p1_ctl <= i_ctl;
            r_p2_ctl <= r_p1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            // A read that races the write-back of the same column takes the new word.
            r_fwd       <= p1_write && (i_col == r_p1_col);
            r_fwd_word  <= n_word;
            r_p1_col    <= i_col;
            r_p1_row    <= i_row;
            r_p1_lane_f <= i_lane_f;
            r_p1_fg     <= i_fg;
        end
        if (r_p1_ctl.valid) begin
            r_p2_cnt   <= f_ones(n_word);
            r_p2_cbit  <= n_word[lane_fc];
            r_p2_csamp <= r_srd;
            r_p2_ci    <= ci_full[COORD_W-1:0];
            r_p2_cj    <= cj_full[COORD_W-1:0];
        end
    end

    assign o_clearing = r_clr_busy;
    assign o_p1_valid = r_p1_ctl.valid;
    assign o_ctl      = r_p2_ctl;
    assign o_col_cnt  = r_p2_cnt;
    assign o_cbit     = r_p2_cbit;
    assign o_csample  = r_p2_csamp;
    assign o_ci       = r_p2_ci;
    assign o_cj       = r_p2_cj;

endmodule

FILE: rtl/core/wdb_window.sv
// Running window count over the last column counts, centre delay line,
// detection decision and slot numbering. Depends on wdb_pkg.
module wdb_window
    import wdb_pkg::*;
#(
    parameter int KERNEL = DEF_KERNEL
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic [$clog2(2*(KERNEL/2)+3)-1:0] i_col_cnt,
    input  logic                i_cbit,
    input  logic [SAMPLE_W-1:0] i_csample,
    input  logic [COORD_W-1:0]  i_ci,
    input  logic [COORD_W-1:0]  i_cj,
    input  logic [CTH_W-1:0]    i_cnt_th,
    input  logic [SLOT_W-1:0]   i_last_slot,
    output logic                o_push,
    output t_det                o_det
);

    localparam int HALF_HI = KERNEL / 2;
    localparam int WIN     = 2 * HALF_HI + 2;
    localparam int CCW     = $clog2(WIN + 1);
    localparam int SUMW    = $clog2(WIN * WIN + 1);
    localparam int CMPW    = (SUMW > CTH_W) ? SUMW : CTH_W;

    logic [CCW-1:0]      r_cnt_sh  [WIN];
    logic [SUMW-1:0]     r_sum;
    logic [HALF_HI-1:0]  r_cbit_sh;
    logic [SAMPLE_W-1:0] r_samp_sh [HALF_HI];
    logic [SLOT_W-1:0]   r_slot;
    logic                r_wrapped;

    logic [SUMW-1:0]   n_sum;
    logic [SLOT_W-1:0] n_slot;
    logic              n_wrapped;
    logic [SLOT_W-1:0] slot_eff;
    logic              wrapped_eff;
    logic              shift_en;
    logic              det;

    assign shift_en = i_ctl.valid && i_ctl.active;

    // The sum always equals the total of the count line, so the oldest entry drops out.
    assign n_sum = r_sum + SUMW'(i_col_cnt) - SUMW'(r_cnt_sh[WIN-1]);

    assign slot_eff    = i_ctl.frame_start ? '0 : r_slot;
    assign wrapped_eff = i_ctl.frame_start ? 1'b0 : r_wrapped;

    assign det = shift_en && i_ctl.judge && (CMPW'(n_sum) > CMPW'(i_cnt_th))
                 && r_cbit_sh[HALF_HI-1];

    always_comb begin
        n_slot    = slot_eff;
        n_wrapped = wrapped_eff;
        if (det) begin
            if (slot_eff >= i_last_slot) begin
                n_slot    = '0;
                n_wrapped = 1'b1;
            end else begin
                n_slot = slot_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) begin
                r_cnt_sh[k] <= '0;
            end
            r_sum     <= '0;
            r_slot    <= '0;
            r_wrapped <= 1'b0;
        end else begin
            if (shift_en) begin
                for (int k = WIN - 1; k > 0; k--) begin
                    r_cnt_sh[k] <= r_cnt_sh[k-1];
                end
                r_cnt_sh[0] <= i_col_cnt;
                r_sum       <= n_sum;
            end
            if (i_ctl.valid) begin
                r_slot    <= n_slot;
                r_wrapped <= n_wrapped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int k = HALF_HI - 1; k > 0; k--) begin
                r_samp_sh[k] <= r_samp_sh[k-1];
            end
            r_samp_sh[0] <= i_csample;
            r_cbit_sh    <= HALF_HI'({r_cbit_sh, i_cbit});
        end
    end

    assign o_push              = det;
    assign o_det.centre_x      = i_cj;
    assign o_det.centre_y      = i_ci;
    assign o_det.centre_value  = r_samp_sh[HALF_HI-1];
    assign o_det.slot          = slot_eff;
    assign o_det.wrapped       = wrapped_eff;

endmodule

FILE: rtl/core/window_density_blob_detector.sv
// Window density blob detector, top level. Takes one depth pixel per cycle in
// raster order and reports every interior centre whose 8 by 8 window (at the
// default kernel) holds more foreground pixels than the count threshold and
// whose own pixel is foreground. Sustained rate is one pixel per cycle: the
// foreground store is a one-word-per-column memory that is read, patched and
// written back every cycle, with forwarding when a column is touched twice
// in a row. A detection is registered through the two store stages and the
// output queue before it is presented at the output. Input stalls only while
// the output queue and the two pipeline stages together hold four possible
// results, and during the clearing sweep after reset that zeroes the line stores
// at 2**(clog2(KERNEL/2+1) + clog2(MAX_WIDTH)) addresses, 4096 at the defaults.
// Configuration may be written at any time the block is idle.
// Depends on wdb_pkg, wdb_store, wdb_window and wdb_fifo.
module window_density_blob_detector
    import wdb_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int KERNEL    = DEF_KERNEL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_W-1:0]    o_centre_x,
    output logic [COORD_W-1:0]    o_centre_y,
    output logic [SAMPLE_W-1:0]   o_centre_value,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_wrapped
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int HALF_HI = KERNEL / 2;
    localparam int WIN     = 2 * HALF_HI + 2;
    localparam int SR      = HALF_HI + 1;
    localparam int LFW     = $clog2(WIN);
    localparam int LSW     = $clog2(SR);
    localparam int CCW     = $clog2(WIN + 1);
    localparam int WDW     = $clog2(MAX_WIDTH + 1);
    localparam int WW      = (WDW > DIM_W) ? WDW : DIM_W;

    function automatic logic [LFW-1:0] f_inc_f(input logic [LFW-1:0] v);
        return (v == LFW'(WIN - 1)) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [LSW-1:0] f_inc_s(input logic [LSW-1:0] v);
        return (v == LSW'(SR - 1)) ? '0 : v + 1'b1;
    endfunction

    logic [DIM_W-1:0]    r_frame_width;
    logic [DIM_W-1:0]    r_frame_height;
    logic [SAMPLE_W-1:0] r_fg_th;
    logic [CTH_W-1:0]    r_cnt_th;
    logic [SLOT_W-1:0]   r_last_slot;

    logic [DIM_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic             r_over;
    logic [LFW-1:0]   r_lane_f;
    logic [LSW-1:0]   r_lane_s;

    logic [DIM_W-1:0] n_row;
    logic [CW-1:0]    n_col;
    logic             n_over;
    logic [LFW-1:0]   n_lane_f;
    logic [LSW-1:0]   n_lane_s;

    logic [WW-1:0]    fw_ext;
    logic [WW-1:0]    w_eff;
    logic             size_zero;
    logic [DIM_W-1:0] row0, row1, row1p;
    logic [WW-1:0]    col0_x, col1_x, col2_x;
    logic             over0;
    logic [LFW-1:0]   lf0, lf1;
    logic [LSW-1:0]   ls0, ls1;
    logic             act;
    logic             judge;
    logic             in_acc;
    t_ctl             s0_ctl;

    logic                 clearing;
    logic                 p1_valid;
    t_ctl                 p2_ctl;
    logic [CCW-1:0]       p2_cnt;
    logic                 p2_cbit;
    logic [SAMPLE_W-1:0]  p2_csamp;
    logic [COORD_W-1:0]   p2_ci;
    logic [COORD_W-1:0]   p2_cj;
    logic                 det_push;
    t_det                 det;
    t_det                 out_det;
    logic [OUT_LVL_W-1:0] out_level;
    logic [OUT_LVL_W:0]   pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_fg_th        <= RST_FG_THRESHOLD;
            r_cnt_th       <= RST_COUNT_THRESHOLD;
            r_last_slot    <= RST_LAST_SLOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:     r_frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:    r_frame_height <= i_cfg_data[DIM_W-1:0];
                REG_FG_THRESHOLD:    r_fg_th        <= i_cfg_data[SAMPLE_W-1:0];
                REG_COUNT_THRESHOLD: r_cnt_th       <= i_cfg_data[CTH_W-1:0];
                REG_LAST_SLOT:       r_last_slot    <= i_cfg_data[SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign fw_ext    = WW'(r_frame_width);
    assign w_eff     = (fw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw_ext;
    assign size_zero = (w_eff == '0) || (r_frame_height == '0);

    // Raster position of the incoming beat and the position after it.
    always_comb begin
        row0   = i_frame_start ? '0 : r_row;
        col0_x = i_frame_start ? '0 : WW'(r_col);
        over0  = i_frame_start ? 1'b0 : r_over;
        lf0    = i_frame_start ? '0 : r_lane_f;
        ls0    = i_frame_start ? '0 : r_lane_s;

        row1   = row0;
        col1_x = col0_x;
        lf1    = lf0;
        ls1    = ls0;
        // A narrowed width can leave the column past the end of the row.
        if (col0_x >= w_eff) begin
            col1_x = '0;
            row1   = row0 + 1'b1;
            lf1    = f_inc_f(lf0);
            ls1    = f_inc_s(ls0);
        end
        col2_x = col1_x + 1'b1;
        row1p  = row1 + 1'b1;

        act   = !over0 && !size_zero && (row1 < r_frame_height);
        judge = (row1 >= DIM_W'(WIN - 1)) && (col1_x >= WW'(WIN - 1))
                && (row1p < r_frame_height) && (col2_x < w_eff);

        n_row    = row0;
        n_col    = col0_x[CW-1:0];
        n_over   = over0;
        n_lane_f = lf0;
        n_lane_s = ls0;
        if (!over0 && !size_zero) begin
            if (!act) begin
                n_over   = 1'b1;
                n_row    = row1;
                n_col    = col1_x[CW-1:0];
                n_lane_f = lf1;
                n_lane_s = ls1;
            end else if (col2_x >= w_eff) begin
                n_col    = '0;
                n_row    = row1p;
                n_lane_f = f_inc_f(lf1);
                n_lane_s = f_inc_s(ls1);
                n_over   = (row1p >= r_frame_height);
            end else begin
                n_col    = col2_x[CW-1:0];
                n_row    = row1;
                n_lane_f = lf1;
                n_lane_s = ls1;
            end
        end
    end

    assign pending = (OUT_LVL_W + 1)'(out_level) + (OUT_LVL_W + 1)'(p1_valid)
                     + (OUT_LVL_W + 1)'(p2_ctl.valid);
    assign o_in_stall = clearing || (pending >= (OUT_LVL_W + 1)'(OUT_DEPTH));
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_over   <= 1'b0;
            r_lane_f <= '0;
            r_lane_s <= '0;
        end else if (in_acc) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_over   <= n_over;
            r_lane_f <= n_lane_f;
            r_lane_s <= n_lane_s;
        end
    end

    assign s0_ctl.valid       = in_acc;
    assign s0_ctl.active      = act;
    assign s0_ctl.frame_start = i_frame_start;
    assign s0_ctl.judge       = judge;

    wdb_store #(
        .MAX_WIDTH(MAX_WIDTH),
        .KERNEL   (KERNEL)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s0_ctl),
        .i_col     (col1_x[CW-1:0]),
        .i_row     (row1),
        .i_lane_f  (lf1),
        .i_lane_s  (ls1),
        .i_fg      (i_sample > r_fg_th),
        .i_sample  (i_sample),
        .o_clearing(clearing),
        .o_p1_valid(p1_valid),
        .o_ctl     (p2_ctl),
        .o_col_cnt (p2_cnt),
        .o_cbit    (p2_cbit),
        .o_csample (p2_csamp),
        .o_ci      (p2_ci),
        .o_cj      (p2_cj)
    );

    wdb_window #(
        .KERNEL(KERNEL)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (p2_ctl),
        .i_col_cnt  (p2_cnt),
        .i_cbit     (p2_cbit),
        .i_csample  (p2_csamp),
        .i_ci       (p2_ci),
        .i_cj       (p2_cj),
        .i_cnt_th   (r_cnt_th),
        .i_last_slot(r_last_slot),
        .o_push     (det_push),
        .o_det      (det)
    );

    wdb_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (det_push),
        .i_det  (det),
        .i_stall(i_out_stall),
        .o_valid(o_out_valid),
        .o_det  (out_det),
        .o_level(out_level)
    );

    assign o_centre_x     = out_det.centre_x;
    assign o_centre_y     = out_det.centre_y;
    assign o_centre_value = out_det.centre_value;
    assign o_slot         = out_det.slot;
    assign o_wrapped      = out_det.wrapped;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for window_density_blob_detector: drives random raster
// frames through the valid/stall channels and checks every detection in order.
// Depends on wdb_pkg and the detector RTL.
module tb;
    import wdb_pkg::*;

    // Tracks the frame position, line stores and slot counter of the detector
    // and keeps the detections that are still due at the output.
    class density_tracker;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned fg_thr;
        int unsigned cnt_thr;
        int unsigned last_slot_reg;
        bit          fg_rows [8][1024];
        bit [15:0]   sample_rows [4][1024];
        int unsigned row_pos;
        int unsigned col_pos;
        int unsigned slot_idx;
        bit          wrapped_flag;
        bit          frame_over;
        t_det        pending[$];
        int          mismatches;

        function new();
            width_reg     = RST_FRAME_WIDTH;
            height_reg    = RST_FRAME_HEIGHT;
            fg_thr        = RST_FG_THRESHOLD;
            cnt_thr       = RST_COUNT_THRESHOLD;
            last_slot_reg = RST_LAST_SLOT;
            row_pos       = 0;
            col_pos       = 0;
            slot_idx      = 0;
            wrapped_flag  = 1'b0;
            frame_over    = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_FRAME_WIDTH:     width_reg     = d[DIM_W-1:0];
                REG_FRAME_HEIGHT:    height_reg    = d[DIM_W-1:0];
                REG_FG_THRESHOLD:    fg_thr        = d[SAMPLE_W-1:0];
                REG_COUNT_THRESHOLD: cnt_thr       = d[CTH_W-1:0];
                REG_LAST_SLOT:       last_slot_reg = d[SLOT_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [SAMPLE_W-1:0] s, logic fs);
            int unsigned w;
            int unsigned h;
            int unsigned ci;
            int unsigned cj;
            int unsigned cnt;
            int unsigned k;
            int unsigned l;
            t_det        d;
            w = (width_reg > 1024) ? 1024 : width_reg;
            h = height_reg;
            if (fs) begin
                row_pos      = 0;
                col_pos      = 0;
                slot_idx     = 0;
                wrapped_flag = 1'b0;
                frame_over   = 1'b0;
            end
            if (frame_over || w == 0 || h == 0) return;
            // A width lowered since the last beat can leave the column past the row end.
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) begin
                frame_over = 1'b1;
                return;
            end
            fg_rows[row_pos % 8][col_pos]     = (s > fg_thr);
            sample_rows[row_pos % 4][col_pos] = s;
            // The centre lags the newest pixel by three rows and three columns.
            if (row_pos >= 3 && col_pos >= 3) begin
                ci = row_pos - 3;
                cj = col_pos - 3;
                if (ci >= 4 && cj >= 4 && ci + 4 < h && cj + 4 < w) begin
                    cnt = 0;
                    for (k = ci - 4; k <= ci + 3; k++)
                        for (l = cj - 4; l <= cj + 3; l++)
                            cnt += fg_rows[k % 8][l % 1024];
                    if (cnt > cnt_thr && fg_rows[ci % 8][cj]) begin
                        d.centre_x     = cj[COORD_W-1:0];
                        d.centre_y     = ci[COORD_W-1:0];
                        d.centre_value = sample_rows[ci % 4][cj];
                        d.slot         = slot_idx[SLOT_W-1:0];
                        d.wrapped      = wrapped_flag;
                        pending.push_back(d);
                        if (slot_idx >= last_slot_reg) begin
                            slot_idx     = 0;
                            wrapped_flag = 1'b1;
                        end else begin
                            slot_idx++;
                        end
                    end
                end
            end
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) frame_over = 1'b1;
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void match_detection(t_det got);
            t_det want;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected detection x=%0d y=%0d value=%0d slot=%0d wrapped=%0d",
                         $time, got.centre_x, got.centre_y, got.centre_value, got.slot,
                         got.wrapped);
                return;
            end
            want = pending.pop_front();
            check_field("centre_x", want.centre_x, got.centre_x);
            check_field("centre_y", want.centre_y, got.centre_y);
            check_field("centre_value", want.centre_value, got.centre_value);
            check_field("slot", want.slot, got.slot);
            check_field("wrapped", want.wrapped, got.wrapped);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  i_frame_start;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [COORD_W-1:0]    o_centre_x;
    logic [COORD_W-1:0]    o_centre_y;
    logic [SAMPLE_W-1:0]   o_centre_value;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_wrapped;

    density_tracker tracker;
    bit             steady;
    bit             hold_request;
    int             hold_left;
    int             quiet_cycles;
    int             phase;
    int             sent_items;

    window_density_blob_detector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_centre_x     (o_centre_x),
        .o_centre_y     (o_centre_y),
        .o_centre_value (o_centre_value),
        .o_slot         (o_slot),
        .o_wrapped      (o_wrapped)
    );

    always #1 i_clk = ~i_clk;

    // Ends the run when neither channel moves a beat for too long. The longest
    // legal quiet spell is the clearing sweep after reset.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 20000) begin
            $display("%0t: watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        t_det got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.centre_x     = o_centre_x;
                got.centre_y     = o_centre_y;
                got.centre_value = o_centre_value;
                got.slot         = o_slot;
                got.wrapped      = o_wrapped;
                tracker.match_detection(got);
            end
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = 600;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = !steady && ($urandom_range(99) < 33);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat,
    // with valid still high so a following pixel goes out back to back.
    task automatic send_pixel(input logic [SAMPLE_W-1:0] s, input logic fs);
        while (!steady && $urandom_range(99) < 33) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_sample      = s;
        i_frame_start = fs;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_pixel(s, fs);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (9) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = d;
        tracker.set_reg(idx, d);
        @(negedge i_clk);
    endtask

    // Bits above each register's width are filled at random; the block drops them.
    task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned thr,
                              input int unsigned cth, input int unsigned ls);
        drain();
        write_reg(REG_FRAME_WIDTH, 16'(w) | (16'($urandom) & 16'hF800));
        write_reg(REG_FRAME_HEIGHT, 16'(h) | (16'($urandom) & 16'hF800));
        write_reg(REG_FG_THRESHOLD, 16'(thr));
        write_reg(REG_COUNT_THRESHOLD, 16'(cth) | (16'($urandom) & 16'hFF80));
        write_reg(REG_LAST_SLOT, 16'(ls) | (16'($urandom) & 16'hFC00));
        if ($urandom_range(7) == 0)
            write_reg(CFG_IDX_W'(REG_LAST_SLOT + 1 + $urandom_range(2)), 16'($urandom));
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(int fgp);
        int unsigned thr;
        thr = tracker.fg_thr;
        if ($urandom_range(49) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(99) < fgp && thr < 65535) return 16'($urandom_range(65535, thr + 1));
        return 16'($urandom_range(thr, 0));
    endfunction

    // mode 0 sends the exact frame, 1 cuts it short, 2 runs past its end.
    task automatic run_frame(input bit fresh, input int fgp, input int mode);
        int unsigned w;
        int unsigned n;
        int unsigned i;
        w = (tracker.width_reg > 1024) ? 1024 : tracker.width_reg;
        n = w * tracker.height_reg;
        if (n == 0) n = $urandom_range(8, 3);
        else if (mode == 1) n = $urandom_range(n, 1);
        else if (mode == 2) n = n + $urandom_range(20, 1);
        for (i = 0; i < n; i++)
            send_pixel(pick_sample(fgp), (i == 0) ? fresh : ($urandom_range(199) == 0));
    endtask

    task automatic run_phase(input int p);
        int r;
        int unsigned w;
        int unsigned h;
        int unsigned thr;
        int unsigned cth;
        int unsigned ls;
        int frames;
        int f;
        case (p)
            0: begin
                set_config(9, 9, 0, 0, 0);
                run_frame(1'b1, 100, 0);
            end
            1: begin
                set_config(16, 12, 3277, 20, 5);
                steady = 1'b1;
                run_frame(1'b1, 80, 0);
                steady = 1'b0;
            end
            2: begin
                // Hold the output long enough that the input has to stall.
                set_config(16, 16, 0, 0, 1023);
                hold_request = 1'b1;
                run_frame(1'b1, 100, 0);
            end
            3: begin
                set_config(12, 12, 65535, 0, 3);
                run_frame(1'b1, 100, 0);
            end
            4: begin
                set_config(12, 12, 0, 64, 3);
                run_frame(1'b1, 100, 0);
            end
            5: begin
                set_config(9, 20, 3277, 20, 2);
                run_frame(1'b1, 85, 0);
            end
            6: begin
                set_config(0, 12, 3277, 0, 3);
                run_frame(1'b1, 90, 0);
            end
            7: begin
                set_config(12, 0, 3277, 0, 3);
                run_frame(1'b1, 90, 0);
            end
            default: begin
                r = $urandom_range(99);
                w = (r < 80) ? $urandom_range(16, 9) :
                    (r < 90) ? $urandom_range(40, 17) : $urandom_range(8, 0);
                h = ($urandom_range(99) < 85) ? $urandom_range(14, 9) : $urandom_range(8, 0);
                r = $urandom_range(99);
                thr = (r < 15) ? 0 : (r < 20) ? 65535 : (r < 40) ? 3277 : $urandom_range(65535);
                r = $urandom_range(99);
                cth = (r < 15) ? 0 : (r < 20) ? 64 : (r < 23) ? $urandom_range(127, 65) :
                      $urandom_range(40);
                r = $urandom_range(99);
                ls = (r < 20) ? 0 : (r < 40) ? $urandom_range(3) : (r < 50) ? 1023 :
                     $urandom_range(1023);
                set_config(w, h, thr, cth, ls);
                frames = $urandom_range(2, 1);
                for (f = 0; f < frames; f++) begin
                    // Now and then carry on the old frame under the new size.
                    r = $urandom_range(99);
                    run_frame((f > 0) || ($urandom_range(9) != 0), $urandom_range(100, 40),
                              (r < 10) ? 1 : (r < 20) ? 2 : 0);
                end
            end
        endcase
    endtask

    initial begin
        tracker       = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_FRAME_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_sample      = '0;
        i_frame_start = 1'b0;
        i_out_stall   = 1'b0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        hold_left     = 0;
        quiet_cycles  = 0;
        sent_items    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Sample extremes and the threshold edge under the reset configuration.
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'd3277, 1'b0);
        send_pixel(16'd3278, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'hFFFE, 1'b0);
        send_pixel(16'hAAAA, 1'b1);
        send_pixel(16'h5555, 1'b0);

        phase = 0;
        while ((phase < 8 || sent_items < 1100) && phase < 400) begin
            run_phase(phase);
            phase++;
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/core/wdb_pkg.sv
rtl/core/wdb_fifo.sv
rtl/core/wdb_store.sv
rtl/core/wdb_window.sv
rtl/core/window_density_blob_detector.sv
tb/tb.sv
